FILE: rtl/core/gra_pkg.sv
// Shared operation codes, config register indices and result record type for the grid rectangle allocator.
package gra_pkg;
    localparam logic [2:0] KIND_PLACE  = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_FIND   = 3'd2;
    localparam logic [2:0] KIND_QUERY  = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;

    typedef struct packed {
        logic       ok;
        logic [5:0] id;
        logic [3:0] x;
        logic [3:0] y;
        logic [4:0] w;
        logic [4:0] h;
        logic       rot;
    } result_t;
endpackage

FILE: rtl/core/grid_rectangle_allocator_unit.sv
// Top level: first-fit rectangle allocator on a cell grid with a record table.
//
//  channel   | signals                                         | handshake
//  command   | kind pos_x pos_y item_width item_height rotated | start & !busy
//            | item_id                                         |
//  result    | ok out_id out_x out_y out_width out_height      | done, one cycle
//            | out_rotated                                     |
//  config    | cfg_we cfg_index cfg_wdata                      | cfg_we
//
// At most one cell and one record are read or written per cycle; reads are registered.
// Query reads one cell; place scans records for a free slot, then checks and marks the
// cells of the window; remove reads the record and clears its cells; find checks each
// position cell by cell (data dependent).
// After reset, clear or a config write, a pass wipes one cell and one record a cycle
// over max(MAX_COLS*MAX_ROWS, MAX_RECTS) addresses, with busy high.
// The result is not held off; busy falls in the cycle done is high, except for clear,
// whose beat comes in the first wipe cycle.
module grid_rectangle_allocator_unit
    import gra_pkg::*;
#(
    parameter int MAX_COLS  = 16,
    parameter int MAX_ROWS  = 16,
    parameter int MAX_RECTS = 64
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] kind,
    input  logic [3:0] pos_x,
    input  logic [3:0] pos_y,
    input  logic [4:0] item_width,
    input  logic [4:0] item_height,
    input  logic       rotated,
    input  logic [5:0] item_id,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_wdata,
    output logic       done,
    output logic       ok,
    output logic [5:0] out_id,
    output logic [3:0] out_x,
    output logic [3:0] out_y,
    output logic [4:0] out_width,
    output logic [4:0] out_height,
    output logic       out_rotated
);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NCELL = MAX_COLS * MAX_ROWS;
    localparam int AW    = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int IW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CLRW  = ((NCELL > MAX_RECTS) ? AW : IW) + 1;
    localparam int CLRN  = (NCELL > MAX_RECTS) ? NCELL : MAX_RECTS;

    localparam logic [3:0] S_WIPE  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SLOT  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_CHKW  = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_RREC  = 4'd6;
    localparam logic [3:0] S_RRECW = 4'd7;
    localparam logic [3:0] S_FPOS  = 4'd8;
    localparam logic [3:0] S_QRD   = 4'd9;
    localparam logic [3:0] S_QW    = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_SLW   = 4'd12;

    // cell: valid + owner; record: valid,x,y,w,h,rot
    localparam int RECW = 1 + 4 + 4 + 5 + 5 + 1;
    logic [IW:0]     cell_mem [NCELL];
    logic [RECW-1:0] rec_mem  [MAX_RECTS];

    logic [3:0]  state_reg, state_next;
    logic [4:0]  cols_reg, rows_reg;
    logic [CLRW-1:0] clr_reg, clr_next;
    logic [2:0]  kind_reg;
    logic [4:0]  bx_reg, by_reg, bx_next, by_next;    // base position
    logic [4:0]  dx_reg, dy_reg, dx_next, dy_next;    // offset in window
    logic [4:0]  ew_reg, eh_reg, ew_next, eh_next;    // oriented size
    logic [4:0]  iw_reg, ih_reg;
    logic        rot_reg, rot_next;
    logic        pass_reg, pass_next;                 // 0 mark, 1 clear
    logic [IW:0] slot_reg, slot_next;
    logic [5:0]  iid_reg;
    result_t     res_reg, res_next;
    logic        done_reg, done_next;

    logic [AW-1:0]   c_addr;
    logic            c_we;
    logic [IW:0]     c_wdata;
    logic [IW:0]     c_rdata_reg;
    logic [IW-1:0]   r_addr;
    logic            r_we;
    logic [RECW-1:0] r_wdata;
    logic [RECW-1:0] r_rdata_reg;

    logic [4:0] acols, arows;
    logic [5:0] cx, cy;

    always_comb
    begin
        if (cols_reg == 5'd0) acols = 5'd1;
        else if (32'(cols_reg) > MAX_COLS) acols = 5'(MAX_COLS);
        else acols = cols_reg;
        if (rows_reg == 5'd0) arows = 5'd1;
        else if (32'(rows_reg) > MAX_ROWS) arows = 5'(MAX_ROWS);
        else arows = rows_reg;
    end

    assign cx = {1'b0, bx_reg} + {1'b0, dx_reg};
    assign cy = {1'b0, by_reg} + {1'b0, dy_reg};

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cell_mem[c_addr] <= c_wdata;
        end
        c_rdata_reg <= cell_mem[c_addr];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rec_mem[r_addr] <= r_wdata;
        end
        r_rdata_reg <= rec_mem[r_addr];
    end

    logic       wnd_last_x, wnd_last_y;
    logic [5:0] ew6, eh6;
    assign wnd_last_x = (dx_reg + 5'd1 == ew_reg);
    assign wnd_last_y = (dy_reg + 5'd1 == eh_reg);
    assign ew6 = {1'b0, ew_reg};
    assign eh6 = {1'b0, eh_reg};

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        bx_next = bx_reg; by_next = by_reg;
        dx_next = dx_reg; dy_next = dy_reg;
        ew_next = ew_reg; eh_next = eh_reg;
        rot_next = rot_reg; pass_next = pass_reg;
        slot_next = slot_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        c_addr  = AW'(32'(cy[RW-1:0]) * MAX_COLS + 32'(cx[CW-1:0]));
        c_we    = 1'b0;
        c_wdata = '0;
        r_addr  = slot_reg[IW-1:0];
        r_we    = 1'b0;
        r_wdata = '0;

        unique case (state_reg)
            S_WIPE:
            begin
                c_addr  = clr_reg[AW-1:0];
                c_we    = 32'(clr_reg) < NCELL;
                r_addr  = clr_reg[IW-1:0];
                r_we    = 32'(clr_reg) < MAX_RECTS;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLRN - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    dx_next = '0; dy_next = '0; pass_next = 1'b0;
                    bx_next = {1'b0, pos_x}; by_next = {1'b0, pos_y};
                    rot_next = rotated;
                    ew_next = rotated ? item_height : item_width;
                    eh_next = rotated ? item_width : item_height;
                    slot_next = '0;
                    unique case (kind)
                        KIND_PLACE:  state_next = S_SLOT;
                        KIND_REMOVE:
                        begin
                            if (32'(item_id) < MAX_RECTS)
                            begin
                                slot_next = (IW+1)'(item_id);
                                state_next = S_RREC;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        KIND_FIND:
                        begin
                            bx_next = '0; by_next = '0; rot_next = 1'b0;
                            ew_next = item_width; eh_next = item_height;
                            state_next = S_FPOS;
                        end
                        KIND_QUERY:  state_next = S_QRD;
                        KIND_CLEAR:
                        begin
                            res_next.ok = 1'b1;
                            clr_next = '0;
                            done_next = 1'b1;
                            state_next = S_WIPE;
                        end
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_SLOT:
            begin
                state_next = S_SLW;
            end
            S_SLW:
            begin
                if (!r_rdata_reg[RECW-1])
                begin
                    if (ew_reg == 5'd0 || eh_reg == 5'd0
                        || 6'(bx_reg) + ew6 > 6'(acols) || 6'(by_reg) + eh6 > 6'(arows))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
                else if (32'(slot_reg) == MAX_RECTS - 1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                    r_addr = slot_next[IW-1:0];
                    state_next = S_SLOT;
                end
            end
            S_CHK:
            begin
                state_next = S_CHKW;
            end
            S_CHKW:
            begin
                if (c_rdata_reg[IW])
                begin
                    dx_next = '0; dy_next = '0;
                    if (kind_reg == KIND_FIND)
                    begin
                        state_next = S_FPOS;
                        if (6'(bx_reg) + ew6 + 6'd1 <= 6'(acols))
                        begin
                            bx_next = bx_reg + 5'd1;
                        end
                        else
                        begin
                            bx_next = '0;
                            by_next = by_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (wnd_last_x && wnd_last_y)
                begin
                    dx_next = '0; dy_next = '0;
                    if (kind_reg == KIND_FIND)
                    begin
                        res_next.ok = 1'b1;
                        res_next.x = bx_reg[3:0];
                        res_next.y = by_reg[3:0];
                        res_next.rot = rot_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                    if (wnd_last_x)
                    begin
                        dx_next = '0; dy_next = dy_reg + 5'd1;
                    end
                    else
                    begin
                        dx_next = dx_reg + 5'd1;
                    end
                end
            end
            S_MARK:
            begin
                c_we    = 1'b1;
                c_wdata = pass_reg ? '0 : {1'b1, slot_reg[IW-1:0]};
                if (wnd_last_x && wnd_last_y)
                begin
                    r_we = 1'b1;
                    if (!pass_reg)
                    begin
                        r_wdata = {1'b1, bx_reg[3:0], by_reg[3:0], iw_reg, ih_reg, rot_reg};
                        res_next.ok = 1'b1;
                        res_next.id = 6'(slot_reg);
                    end
                    state_next = S_DONE;
                end
                else if (wnd_last_x)
                begin
                    dx_next = '0; dy_next = dy_reg + 5'd1;
                end
                else
                begin
                    dx_next = dx_reg + 5'd1;
                end
            end
            S_RREC:
            begin
                state_next = S_RRECW;
            end
            S_RRECW:
            begin
                if (r_rdata_reg[RECW-1])
                begin
                    res_next.ok  = 1'b1;
                    res_next.id  = iid_reg;
                    res_next.x   = r_rdata_reg[18:15];
                    res_next.y   = r_rdata_reg[14:11];
                    res_next.w   = r_rdata_reg[10:6];
                    res_next.h   = r_rdata_reg[5:1];
                    res_next.rot = r_rdata_reg[0];
                    bx_next = {1'b0, r_rdata_reg[18:15]};
                    by_next = {1'b0, r_rdata_reg[14:11]};
                    rot_next = r_rdata_reg[0];
                    ew_next = r_rdata_reg[0] ? r_rdata_reg[5:1] : r_rdata_reg[10:6];
                    eh_next = r_rdata_reg[0] ? r_rdata_reg[10:6] : r_rdata_reg[5:1];
                    pass_next = 1'b1;
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FPOS:
            begin
                if (ew_reg == 5'd0 || eh_reg == 5'd0 || ew_reg > acols || eh_reg > arows
                    || 6'(by_reg) + eh6 > 6'(arows))
                begin
                    if (rot_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rot_next = 1'b1;
                        ew_next = ih_reg; eh_next = iw_reg;
                        bx_next = '0; by_next = '0;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_QRD:
            begin
                state_next = S_QW;
            end
            S_QW:
            begin
                if ({1'b0, bx_reg} < 6'(acols) && {1'b0, by_reg} < 6'(arows)
                    && c_rdata_reg[IW])
                begin
                    res_next.ok = 1'b1;
                    res_next.id = 6'(c_rdata_reg[IW-1:0]);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            clr_next = '0;
            state_next = S_WIPE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            clr_reg   <= '0;
            cols_reg  <= 5'd16;
            rows_reg  <= 5'd16;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_COLS[0:0]) cols_reg <= cfg_wdata;
                else rows_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg <= bx_next; by_reg <= by_next;
        dx_reg <= dx_next; dy_reg <= dy_next;
        ew_reg <= ew_next; eh_reg <= eh_next;
        rot_reg <= rot_next; pass_reg <= pass_next;
        slot_reg <= slot_next;
        res_reg <= res_next;
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            iw_reg   <= item_width;
            ih_reg   <= item_height;
            iid_reg  <= item_id;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign ok          = res_reg.ok;
    assign out_id      = res_reg.id;
    assign out_x       = res_reg.x;
    assign out_y       = res_reg.y;
    assign out_width   = res_reg.w;
    assign out_height  = res_reg.h;
    assign out_rotated = res_reg.rot;
endmodule
